>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL of the verdict cache.
// Each macro takes a label, clock, reset, trigger, expected condition and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/hvc_pkg.sv
// Types and fixed constants of the hashed verdict cache.
// Used by hashed_verdict_cache_with_ttl; depends on nothing.
`default_nettype none

package hvc_pkg;

   localparam logic [31:0] FNV_BASIS  = 32'h811c_9dc5;
   localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;
   localparam int          WORD_BYTES = 8;
   localparam int          EXPIRY_W   = 33;
   localparam int          TTL_W      = 16;

   // Configuration register indexes
   localparam int          CSR_IDX_W        = 1;
   localparam logic [0:0]  CSR_CACHE_ENABLE = 1'b0;
   localparam logic [0:0]  CSR_TTL_SECONDS  = 1'b1;

   localparam logic [TTL_W-1:0] TTL_RESET = 16'd60;

   localparam logic CMD_STORE      = 1'b1;
   localparam logic VERDICT_PERMIT = 1'b0;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  key_byte;
      logic        key_last;
      logic        block_verdict;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic permit_hit;
      logic was_store;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/hashed_verdict_cache_with_ttl.sv
// Direct-mapped verdict cache with TTL, keyed by an FNV-1a hash of a text key.
// Depends on hvc_pkg, hvc_ram and assert_macros.svh.
//
// Use: send the key one character per word on req_ (valid/stall); the word with
// key_last set carries cmd (check or store), the verdict and the current time.
// Exactly one rsp_ word follows each final character: permit_hit for a check,
// was_store set for a store. Configuration (cache_enable, ttl_seconds) is written
// through csr_ while no operation is in flight: the user's duty, not enforced.
// Timing: a non-final character is taken while req_stall is low. A final character
// holds req_stall high while the key memory is walked one 8-byte word per cycle;
// the rsp_ word is loaded in the DONE state after that walk for a check or a store,
// with no walk when the cache is disabled, and req_stall drops in the same cycle as
// rsp_valid rises. When BUCKETS is not a power of two a reciprocal-multiply remainder
// in the MOD state comes first. The key memory port sets the pace of the walk.
// Reset: control registers return to defaults and a clearing pass writes every expiry
// entry to zero, with req_stall high.
// A stalled rsp_ word is held in the output register; new characters are
// still taken, and a finished operation waits until the register frees.
`default_nettype none
`include "assert_macros.svh"

module hashed_verdict_cache_with_ttl #(
   parameter int BUCKETS   = 1024,
   parameter int KEY_BYTES = 45
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire hvc_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output hvc_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire logic [hvc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [hvc_pkg::TTL_W-1:0]     csr_wdata
);

   localparam int  BW        = $clog2(BUCKETS);
   localparam bit  POW2      = ((BUCKETS & (BUCKETS - 1)) == 0);
   localparam int  LW        = $clog2(KEY_BYTES + 1);
   localparam int  KEY_WORDS = (KEY_BYTES + hvc_pkg::WORD_BYTES - 1) / hvc_pkg::WORD_BYTES;
   localparam int  WIDX      = $clog2(KEY_WORDS);
   localparam int  SW        = WIDX + 1;
   localparam int  KAW       = BW + WIDX;
   localparam int  KDEPTH    = BUCKETS * (2 ** WIDX);
   localparam int  WORD_W    = 8 * hvc_pkg::WORD_BYTES;
   localparam int  EW        = hvc_pkg::EXPIRY_W;
   localparam int  MW        = 1 + LW + EW;
   localparam int  PW        = WIDX + 3;
   localparam int  CW        = (PW > LW) ? PW : LW;
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUCKETS);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_MOD   = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_STORE = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [31:0]            hash_ff, hash_in;
   logic [LW-1:0]          key_len_ff, key_len_in;
   logic [BW-1:0]          bucket_ff, bucket_in;
   logic [BW-1:0]          clr_ff, clr_in;
   logic [1:0]             modcnt_ff, modcnt_in;
   logic [SW-1:0]          step_ff, step_in;
   logic                   miss_ff, miss_in;
   logic                   hit_ff, hit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   hvc_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic                   enable_ff;
   logic [hvc_pkg::TTL_W-1:0] ttl_ff;

   // operation payload, latched on the final character; quot_ff and rem_ff in ST_MOD
   logic                   cmd_ff;
   logic                   verdict_ff;
   logic [31:0]            now_ff;
   logic [31:0]            hash_fin_ff;
   logic [31:0]            quot_ff;
   logic [BW:0]            rem_ff;

   logic [WORD_W-1:0]      kbuf_ff [KEY_WORDS];

   logic                   req_acc;
   logic [31:0]            hash_prod;
   logic [WIDX-1:0]        kb_widx;
   logic [63:0]            quot_prod;
   logic [BW:0]            rem_calc;
   logic [BW-1:0]          rem_next;
   logic [WIDX-1:0]        cmp_idx;
   logic [WORD_W-1:0]      cmp_mask;
   logic                   word_diff;
   logic [EW-1:0]          expiry_sum;
   logic                   live;
   logic                   len_eq;

   logic                   meta_we, meta_re;
   logic [BW-1:0]          meta_waddr;
   logic [MW-1:0]          meta_wdata, meta_rdata;
   logic                   key_we, key_re;
   logic [KAW-1:0]         key_addr;
   logic [WORD_W-1:0]      key_rdata;

   function automatic state_type pick_op(input logic en, input logic store);
      state_type s;
      if (!en) begin
         s = ST_DONE;
      end else if (store == hvc_pkg::CMD_STORE) begin
         s = ST_STORE;
      end else begin
         s = ST_CHECK;
      end
      return s;
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign hash_prod = (hash_ff ^ {24'd0, req_data.key_byte}) * hvc_pkg::FNV_PRIME;
   assign kb_widx   = WIDX'(key_len_ff >> 3);

   // hash mod BUCKETS: the reciprocal quotient is low by at most one,
   // so one compare and subtract finishes the remainder
   assign quot_prod = 64'(hash_fin_ff) * 64'(RECIP);
   assign rem_calc  = (BW+1)'(hash_fin_ff - quot_ff * 32'(BUCKETS));
   assign rem_next  = (rem_ff >= (BW+1)'(BUCKETS)) ? BW'(rem_ff - (BW+1)'(BUCKETS))
                                                   : BW'(rem_ff);

   assign key_addr   = {bucket_ff, step_ff[WIDX-1:0]};
   assign cmp_idx    = WIDX'(step_ff - SW'(1));
   assign expiry_sum = {1'b0, now_ff} + EW'(ttl_ff);
   assign meta_wdata = (state_ff == ST_CLEAR) ? '0 : {verdict_ff, key_len_ff, expiry_sum};

   // only bytes below the key length take part in the compare
   always_comb begin
      logic [CW-1:0] pos;
      for (int b = 0; b < hvc_pkg::WORD_BYTES; b++) begin
         pos = CW'({cmp_idx, 3'(b)});
         cmp_mask[b*8 +: 8] = {8{pos < CW'(key_len_ff)}};
      end
   end

   assign word_diff = |((key_rdata ^ kbuf_ff[cmp_idx]) & cmp_mask);
   assign live      = (meta_rdata[EW-1:0] != '0) && ({1'b0, now_ff} < meta_rdata[EW-1:0]);
   assign len_eq    = (meta_rdata[EW +: LW] == key_len_ff);

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      key_len_in   = key_len_ff;
      bucket_in    = bucket_ff;
      clr_in       = clr_ff;
      modcnt_in    = modcnt_ff;
      step_in      = step_ff;
      miss_in      = miss_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      meta_we      = 1'b0;
      meta_re      = 1'b0;
      meta_waddr   = bucket_ff;
      key_we       = 1'b0;
      key_re       = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            clr_in     = clr_ff + BW'(1);
            if (clr_ff == BW'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               hash_in = hash_prod;
               if (key_len_ff < LW'(KEY_BYTES)) begin
                  key_len_in = key_len_ff + LW'(1);
               end
               if (req_data.key_last) begin
                  hash_in   = hvc_pkg::FNV_BASIS;
                  hit_in    = 1'b0;
                  miss_in   = 1'b0;
                  step_in   = '0;
                  modcnt_in = '0;
                  if (POW2) begin
                     bucket_in = hash_prod[BW-1:0];
                     state_in  = pick_op(enable_ff, req_data.cmd);
                  end else begin
                     bucket_in = '0;
                     state_in  = ST_MOD;
                  end
               end
            end
         end
         ST_MOD: begin
            // quotient, then remainder, then correction
            modcnt_in = modcnt_ff + 2'd1;
            if (modcnt_ff == 2'd2) begin
               bucket_in = rem_next;
               state_in  = pick_op(enable_ff, cmd_ff);
            end
         end
         ST_CHECK: begin
            key_re  = (step_ff < SW'(KEY_WORDS));
            meta_re = (step_ff == '0);
            step_in = step_ff + SW'(1);
            if (step_ff != '0) begin
               miss_in = miss_ff | word_diff;
            end
            if (step_ff == SW'(KEY_WORDS)) begin
               hit_in   = live && len_eq && !(miss_ff || word_diff) &&
                          (meta_rdata[MW-1] == hvc_pkg::VERDICT_PERMIT);
               state_in = ST_DONE;
            end
         end
         ST_STORE: begin
            key_we  = 1'b1;
            meta_we = (step_ff == '0);
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(KEY_WORDS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.permit_hit = hit_ff;
               rsp_data_in.was_store  = cmd_ff;
               key_len_in             = '0;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         hash_ff      <= hvc_pkg::FNV_BASIS;
         key_len_ff   <= '0;
         clr_ff       <= '0;
         modcnt_ff    <= '0;
         step_ff      <= '0;
         miss_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         key_len_ff   <= key_len_in;
         clr_ff       <= clr_in;
         modcnt_ff    <= modcnt_in;
         step_ff      <= step_in;
         miss_ff      <= miss_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bucket_ff   <= bucket_in;
      rsp_data_ff <= rsp_data_in;
      if (req_acc && req_data.key_last) begin
         cmd_ff      <= req_data.cmd;
         verdict_ff  <= req_data.block_verdict;
         now_ff      <= req_data.now_seconds;
         hash_fin_ff <= hash_prod;
      end else if (state_ff == ST_MOD) begin
         quot_ff <= quot_prod[63:32];
         rem_ff  <= rem_calc;
      end
   end

   // buffer the first KEY_BYTES characters
   always_ff @(posedge clock) begin
      if (req_acc && (key_len_ff < LW'(KEY_BYTES))) begin
         kbuf_ff[kb_widx][{key_len_ff[2:0], 3'b000} +: 8] <= req_data.key_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         ttl_ff    <= hvc_pkg::TTL_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            hvc_pkg::CSR_CACHE_ENABLE: enable_ff <= csr_wdata[0];
            hvc_pkg::CSR_TTL_SECONDS:  ttl_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // entry metadata: verdict, key length, expiry
   hvc_ram #(
      .WIDTH (MW),
      .DEPTH (BUCKETS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (meta_re),
      .rd_addr (bucket_ff),
      .rd_data (meta_rdata)
   );

   // stored keys, one 8-byte word per row, rows grouped by bucket
   hvc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (KDEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_addr),
      .wr_data (kbuf_ff[step_ff[WIDX-1:0]]),
      .rd_en   (key_re),
      .rd_addr (key_addr),
      .rd_data (key_rdata)
   );

   `ASSERT_IMPLIES(a_meta_port, clock, reset, meta_we, !meta_re, "meta RAM read and write overlap")
   `ASSERT_IMPLIES(a_rsp_src, clock, reset, rsp_valid_ff && !$past(rsp_valid_ff), $past(state_ff) == ST_DONE, "response loaded outside DONE")
   `ASSERT_IMPLIES(a_key_len, clock, reset, 1'b1, key_len_ff <= LW'(KEY_BYTES), "key length beyond buffer")
   `ASSERT_NEXT(a_done_hold, clock, reset, state_ff == ST_DONE && rsp_valid_ff && rsp_stall, state_ff == ST_DONE, "result dropped while output stalled")

endmodule

`default_nettype wire

>>> sv/hvc_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Used by hashed_verdict_cache_with_ttl for the key and entry memories; no dependencies.
`default_nettype none

module hvc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> tb/tb_hashed_verdict_cache_with_ttl.sv
// Testbench for hashed_verdict_cache_with_ttl: drives key characters and time on req_,
// checks permit/store results on rsp_ against a built-in cache predictor.
// Depends on hvc_pkg and the cache RTL.

module tb_hashed_verdict_cache_with_ttl;
   timeunit 1ns;
   timeprecision 1ps;

   import hvc_pkg::*;

   localparam int   BUCKETS      = 1024;
   localparam int   KEY_BYTES    = 45;
   localparam int   KEY_MAX      = 60;
   localparam int   POOL         = 48;
   localparam int   DRAIN_CYCLES = 48;
   localparam logic CMD_CHECK     = ~CMD_STORE;
   localparam logic VERDICT_BLOCK = ~VERDICT_PERMIT;

   // Mirror of the cache: hashes characters, keeps the buckets, queues verdicts.
   class verdict_scoreboard;
      bit                  enable;
      bit [TTL_W-1:0]      ttl;
      bit [31:0]           hash;
      bit [7:0]            key_buf [KEY_BYTES];
      int unsigned         key_len;
      bit [7:0]            line_key [BUCKETS][KEY_BYTES];
      int unsigned         line_len [BUCKETS];
      bit                  line_verdict [BUCKETS];
      bit [EXPIRY_W-1:0]   line_expiry [BUCKETS];
      rsp_type             due_verdicts [$];
      int                  mismatches;

      function new();
         enable     = 1'b1;
         ttl        = TTL_RESET;
         hash       = FNV_BASIS;
         key_len    = 0;
         mismatches = 0;
         foreach (line_expiry[b]) line_expiry[b] = '0;
      endfunction

      function void take_char(req_type w);
         int unsigned b;
         bit          hit;
         rsp_type     v;
         hash = (hash ^ {24'd0, w.key_byte}) * FNV_PRIME;
         // characters past the buffer are hashed only
         if (key_len < KEY_BYTES) begin
            key_buf[key_len] = w.key_byte;
            key_len++;
         end
         if (!w.key_last) return;
         b   = hash % BUCKETS;
         hit = 1'b0;
         if (w.cmd != CMD_STORE) begin
            if (enable && line_expiry[b] != 0 && {1'b0, w.now_seconds} < line_expiry[b] &&
                line_len[b] == key_len && line_verdict[b] == VERDICT_PERMIT) begin
               hit = 1'b1;
               for (int i = 0; i < key_len; i++) begin
                  if (line_key[b][i] != key_buf[i]) hit = 1'b0;
               end
            end
         end else if (enable) begin
            for (int i = 0; i < key_len; i++) line_key[b][i] = key_buf[i];
            line_len[b]     = key_len;
            line_verdict[b] = w.block_verdict;
            line_expiry[b]  = {1'b0, w.now_seconds} + ttl;
         end
         v.permit_hit = hit;
         v.was_store  = w.cmd;
         due_verdicts.push_back(v);
         hash    = FNV_BASIS;
         key_len = 0;
      endfunction

      task match_verdict(rsp_type got);
         rsp_type want;
         if (due_verdicts.size() == 0) begin
            report($sformatf("verdict with none due: permit_hit %b was_store %b",
                             got.permit_hit, got.was_store));
            return;
         end
         want = due_verdicts.pop_front();
         if (got.permit_hit !== want.permit_hit || got.was_store !== want.was_store) begin
            report($sformatf("permit_hit %b (want %b) was_store %b (want %b)",
                             got.permit_hit, want.permit_hit, got.was_store, want.was_store));
         end
      endtask

      task report(string what);
         $display("ERROR at %0t: %s", $realtime, what);
         mismatches++;
      endtask
   endclass

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TTL_W-1:0]     csr_wdata = '0;

   verdict_scoreboard sb;
   bit [7:0]          pool_key [POOL+1][KEY_MAX];
   int                pool_len [POOL+1];
   int                words_sent    = 0;
   int                send_idle_pct = 0;
   int                stall_pct     = 0;
   int                stall_left    = 0;
   bit [31:0]         clock_base    = '0;

   hashed_verdict_cache_with_ttl #(.BUCKETS(BUCKETS), .KEY_BYTES(KEY_BYTES)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10ns clock = ~clock;

   initial begin
      #10ms;
      $display("hashed_verdict_cache_with_ttl verification failed");
      $finish;
   end

   // Result side: check accepted words, then stall in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.match_verdict(rsp_data);
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void fill_key(int k, int len, int from);
      pool_len[k] = len;
      for (int i = from; i < len; i++) pool_key[k][i] = 8'($urandom_range(1, 255));
   endfunction

   function automatic int unsigned pool_bucket(int k);
      bit [31:0] h;
      h = FNV_BASIS;
      for (int i = 0; i < pool_len[k]; i++) h = (h ^ {24'd0, pool_key[k][i]}) * FNV_PRIME;
      return h % BUCKETS;
   endfunction

   task automatic send_word(req_type w);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_char(w);
      words_sent++;
   endtask

   // Send pool key k; only the final word carries the real command, verdict and time.
   task automatic send_key(int k, logic cmd, logic verdict, bit [31:0] now);
      req_type w;
      for (int i = 0; i < pool_len[k]; i++) begin
         w.cmd           = 1'($urandom);
         w.block_verdict = 1'($urandom);
         w.now_seconds   = $urandom;
         w.key_byte      = pool_key[k][i];
         w.key_last      = (i == pool_len[k] - 1);
         if (w.key_last) begin
            w.cmd           = cmd;
            w.block_verdict = verdict;
            w.now_seconds   = now;
         end
         send_word(w);
      end
   endtask

   // Hold the sender until every verdict is in and the block has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.due_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csrs(logic en, logic [TTL_W-1:0] ttl);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CACHE_ENABLE;
      csr_wdata <= TTL_W'(en);
      @(posedge clock);
      sb.enable = en;
      csr_index <= CSR_TTL_SECONDS;
      csr_wdata <= ttl;
      @(posedge clock);
      sb.ttl = ttl;
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_op();
      int        k;
      logic      cmd;
      logic      verdict;
      bit [31:0] now;
      if ($urandom_range(0, 9) == 0) begin
         k = POOL;
         fill_key(POOL, ($urandom_range(0, 3) == 0) ? $urandom_range(9, KEY_MAX)
                                                     : $urandom_range(1, 8), 0);
      end else if ($urandom_range(0, 99) < 15) begin
         k = $urandom_range(36, POOL - 1);
      end else begin
         k = $urandom_range(0, 35);
      end
      if ($urandom_range(0, 7) == 0) clock_base += $urandom_range(20, 200);
      else clock_base += $urandom_range(0, 3);
      now     = ($urandom_range(0, 19) == 0) ? $urandom : clock_base;
      cmd     = ($urandom_range(0, 9) < 4) ? CMD_STORE : CMD_CHECK;
      verdict = ($urandom_range(0, 99) < 35) ? VERDICT_BLOCK : VERDICT_PERMIT;
      send_key(k, cmd, verdict, now);
   endtask

   task automatic run_phase(logic en, logic [TTL_W-1:0] ttl, bit [31:0] base,
                            int idle_pct, int words);
      int target;
      settle();
      write_csrs(en, ttl);
      clock_base    = base;
      send_idle_pct = idle_pct;
      stall_pct     = idle_pct;
      target        = words_sent + words;
      while (words_sent < target) random_op();
   endtask

   initial begin
      int len;
      sb = new();

      // Fixed keys for the directed part
      pool_len[0] = 1;  pool_key[0][0] = 8'h41;
      pool_len[1] = 1;  pool_key[1][0] = 8'hFF;
      pool_len[2] = 1;  pool_key[2][0] = 8'h01;
      pool_len[3] = 2;  pool_key[3][0] = 8'h80;  pool_key[3][1] = 8'h7F;
      for (int k = 4; k < 24; k++) begin
         fill_key(k, ($urandom_range(0, 4) == 0) ? $urandom_range(9, 30)
                                                 : $urandom_range(1, 8), 0);
      end
      // Different keys landing in the bucket of an earlier key
      for (int k = 24; k < 36; k++) begin
         do begin
            len = (pool_len[k-20] >= 2 && $urandom_range(0, 1) == 1) ? pool_len[k-20]
                                                                     : $urandom_range(2, 6);
            fill_key(k, len, 0);
         end while (pool_bucket(k) != pool_bucket(k - 20));
      end
      for (int k = 36; k < 42; k++) fill_key(k, $urandom_range(KEY_BYTES + 1, KEY_MAX), 0);
      // Long keys that share the buffered prefix and the bucket of another long key
      for (int k = 42; k < POOL; k++) begin
         for (int i = 0; i < KEY_BYTES; i++) pool_key[k][i] = pool_key[k-6][i];
         do begin
            fill_key(k, $urandom_range(KEY_BYTES + 1, KEY_MAX), KEY_BYTES);
         end while (pool_bucket(k) != pool_bucket(k - 6));
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 25;
      stall_pct     = 25;

      // Reset settings: empty miss, expiry boundary, block verdict, 33-bit expiry
      send_key(0, CMD_CHECK, VERDICT_PERMIT, 32'd5);
      send_key(0, CMD_STORE, VERDICT_PERMIT, 32'd100);
      send_key(0, CMD_CHECK, VERDICT_PERMIT, 32'd159);
      send_key(0, CMD_CHECK, VERDICT_PERMIT, 32'd160);
      send_key(1, CMD_STORE, VERDICT_BLOCK, 32'hFFFF_FFFF);
      send_key(1, CMD_CHECK, VERDICT_PERMIT, 32'hFFFF_FFFF);
      send_key(2, CMD_STORE, VERDICT_PERMIT, 32'hFFFF_FFFF);
      send_key(2, CMD_CHECK, VERDICT_PERMIT, 32'hFFFF_FFFF);
      send_key(3, CMD_STORE, VERDICT_PERMIT, 32'd7);
      send_key(3, CMD_CHECK, VERDICT_PERMIT, 32'd8);

      // Zero expiry sum leaves the bucket empty
      settle();
      write_csrs(1'b1, 16'd0);
      send_key(0, CMD_STORE, VERDICT_PERMIT, 32'd0);
      send_key(0, CMD_CHECK, VERDICT_PERMIT, 32'd0);

      // Disabled: store writes nothing, check misses
      settle();
      write_csrs(1'b0, 16'hFFFF);
      send_key(3, CMD_STORE, VERDICT_BLOCK, 32'd9);
      send_key(3, CMD_CHECK, VERDICT_PERMIT, 32'd9);
      settle();
      write_csrs(1'b1, 16'hFFFF);
      send_key(3, CMD_CHECK, VERDICT_PERMIT, 32'd9);

      run_phase(1'b1, TTL_RESET, 32'd1000, 25, 330);
      run_phase(1'b1, 16'd1, 32'd5000, 0, 330);
      run_phase(1'b0, 16'($urandom), 32'd6000, 30, 330);
      run_phase(1'b1, 16'hFFFF, 32'hFFFF_FF00, 25, 330);
      run_phase(1'b1, 16'd0, 32'd0, 20, 330);
      run_phase(1'b1, 16'($urandom_range(2, 300)), 32'd9000, 0, 330);
      settle();

      if (sb.mismatches == 0) begin
         $display("hashed_verdict_cache_with_ttl verification clean");
      end else begin
         $display("hashed_verdict_cache_with_ttl verification failed");
      end
      $finish;
   end

endmodule
